FILE: sv/pgcm_pkg.sv
// package: register codes, palette defaults and field widths for the gradient color map
package pgcm_pkg;

  localparam int PALETTE_SIZE = 5;
  localparam int COLOR_W      = 24;
  localparam int CHAN_W       = 8;
  localparam int NUM_CHAN     = 3;
  localparam int INDEX_W      = 3;
  localparam int ENTRY_W      = 3;
  localparam int LIMIT_CFG_W  = 16;
  localparam int SEG_W        = 2;

  localparam logic [LIMIT_CFG_W-1:0] LIMIT_RESET = 16'd100;

  localparam logic [PALETTE_SIZE-1:0][COLOR_W-1:0] PALETTE_RESET = {
    24'hFF007F, 24'h140000, 24'h000033, 24'h323233, 24'h000000
  };

  typedef logic [PALETTE_SIZE-1:0][COLOR_W-1:0] palette_t;

  typedef enum logic [INDEX_W-1:0] {
    REG_LIMIT = 3'd0,
    REG_PAL0  = 3'd1,
    REG_PAL1  = 3'd2,
    REG_PAL2  = 3'd3,
    REG_PAL3  = 3'd4,
    REG_PAL4  = 3'd5
  } reg_index_t;

endpackage

FILE: sv/pgcm_if.sv
// stream interfaces: iteration counts in, rgb colors out
interface pgcm_count_if #(
  parameter int COUNT_BITS = 16
) ();
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] iteration_count;

  modport source (output valid, output iteration_count, input ready);
  modport sink (input valid, input iteration_count, output ready);
endinterface

interface pgcm_color_if ();
  logic                        valid;
  logic                        ready;
  logic [pgcm_pkg::CHAN_W-1:0] red;
  logic [pgcm_pkg::CHAN_W-1:0] green;
  logic [pgcm_pkg::CHAN_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

FILE: sv/pgcm_div_cell.sv
// one restoring-division cell: doubles the remainder, subtracts the limit, appends a quotient bit
module pgcm_div_cell #(
  parameter int COUNT_BITS = 16,
  parameter int QUOT_BITS  = 18
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [COUNT_BITS-1:0] limit,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_sat,
  input  logic [COUNT_BITS-1:0] in_rem,
  input  logic [QUOT_BITS-1:0]  in_quot,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_sat,
  output logic [COUNT_BITS-1:0] out_rem,
  output logic [QUOT_BITS-1:0]  out_quot
);

  logic                  valid;
  logic                  sat;
  logic [COUNT_BITS-1:0] rem;
  logic [QUOT_BITS-1:0]  quot;
  logic [COUNT_BITS:0]   rem_x2;
  logic [COUNT_BITS:0]   rem_diff;
  logic                  take;
  logic [COUNT_BITS-1:0] rem_next;
  logic [QUOT_BITS-1:0]  quot_next;

  assign in_ready = !valid || out_ready;

  // remainder stays below the limit, so the doubled value fits one extra bit
  always_comb begin
    rem_x2    = {in_rem, 1'b0};
    rem_diff  = rem_x2 - {1'b0, limit};
    take      = (rem_x2 >= {1'b0, limit});
    rem_next  = take ? rem_diff[COUNT_BITS-1:0] : rem_x2[COUNT_BITS-1:0];
    quot_next = {in_quot[QUOT_BITS-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sat  <= in_sat;
      rem  <= rem_next;
      quot <= quot_next;
    end
  end

  assign out_valid = valid;
  assign out_sat   = sat;
  assign out_rem   = rem;
  assign out_quot  = quot;

endmodule

FILE: sv/pgcm_blend.sv
// palette select and per-channel linear blend, with the output register
module pgcm_blend #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  pgcm_pkg::palette_t         palette,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_sat,
  input  logic [FRACTION_BITS+1:0]   in_quot,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [pgcm_pkg::CHAN_W-1:0] out_red,
  output logic [pgcm_pkg::CHAN_W-1:0] out_green,
  output logic [pgcm_pkg::CHAN_W-1:0] out_blue
);

  localparam int QUOT_BITS = FRACTION_BITS + pgcm_pkg::SEG_W;
  localparam int SUM_W     = FRACTION_BITS + pgcm_pkg::CHAN_W + 2;

  logic                                    valid;
  logic [pgcm_pkg::SEG_W-1:0]              seg;
  logic [FRACTION_BITS-1:0]                frac;
  logic [pgcm_pkg::ENTRY_W-1:0]            lo_idx;
  logic [pgcm_pkg::ENTRY_W-1:0]            hi_idx;
  logic [pgcm_pkg::COLOR_W-1:0]            lo_color;
  logic [pgcm_pkg::COLOR_W-1:0]            hi_color;
  logic [pgcm_pkg::COLOR_W-1:0]            last_color;
  logic [pgcm_pkg::NUM_CHAN-1:0][pgcm_pkg::CHAN_W-1:0] chan_next;
  logic [pgcm_pkg::NUM_CHAN-1:0][pgcm_pkg::CHAN_W-1:0] chan;

  assign in_ready = !valid || out_ready;

  always_comb begin
    seg        = in_quot[QUOT_BITS-1 -: pgcm_pkg::SEG_W];
    frac       = in_quot[FRACTION_BITS-1:0];
    lo_idx     = pgcm_pkg::ENTRY_W'(seg);
    hi_idx     = lo_idx + pgcm_pkg::ENTRY_W'(1);
    lo_color   = palette[lo_idx];
    hi_color   = palette[hi_idx];
    last_color = palette[pgcm_pkg::PALETTE_SIZE-1];
  end

  // channel 0 is red, taken from the top byte
  for (genvar c = 0; c < pgcm_pkg::NUM_CHAN; c++) begin : g_lane
    localparam int SH = pgcm_pkg::CHAN_W * (pgcm_pkg::NUM_CHAN - 1 - c);
    logic [pgcm_pkg::CHAN_W-1:0]   lo;
    logic [pgcm_pkg::CHAN_W-1:0]   hi;
    logic signed [pgcm_pkg::CHAN_W:0] diff;
    logic signed [FRACTION_BITS:0] weight;
    logic signed [SUM_W-1:0]       prod;
    logic signed [SUM_W-1:0]       sum;

    // lo + (hi - lo) * t, floored; the sum never goes negative
    always_comb begin
      lo     = lo_color[SH +: pgcm_pkg::CHAN_W];
      hi     = hi_color[SH +: pgcm_pkg::CHAN_W];
      diff   = $signed({1'b0, hi}) - $signed({1'b0, lo});
      weight = $signed({1'b0, frac});
      prod   = SUM_W'(diff) * SUM_W'(weight);
      sum    = prod + $signed({2'b00, lo, {FRACTION_BITS{1'b0}}});
      if (in_sat) begin
        chan_next[c] = last_color[SH +: pgcm_pkg::CHAN_W];
      end else begin
        chan_next[c] = sum[FRACTION_BITS +: pgcm_pkg::CHAN_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      chan <= chan_next;
    end
  end

  assign out_valid = valid;
  assign out_red   = chan[0];
  assign out_green = chan[1];
  assign out_blue  = chan[2];

endmodule

FILE: sv/palette_gradient_color_map_top.sv
// Gradient palette color map: iteration count in, interpolated rgb out.
// pixel_in carries one iteration count per transaction (valid/ready);
// color_out carries the red, green and blue bytes of the matching pixel.
// Results leave in the order the counts arrived, one per count.
// Position 4*count/limit is formed by a chain of FRACTION_BITS+2 division
// cells, one quotient bit per cell, followed by a blend stage that holds
// the output register; each cell and the blend stage is registered, and
// one pixel is taken every cycle in steady state while color_out is ready.
// Every stage has its own valid bit and advances whenever the stage after
// it is empty or moving, so a stalled receiver backs up only the filled
// stages; bubbles are squeezed out and pixel_in stays ready until the
// whole chain is full.
// Counts at or above the limit (or any count with a limit of zero) give
// palette entry 4 unchanged.
// Configuration writes (index 0 limit, 1..5 palette entries) take effect at
// once; the user must make them only while the chain is empty, and the
// block does not enforce it. Other indexes are ignored. Reset empties
// the chain and loads the default limit of 100 and the default palette.
module palette_gradient_color_map_top #(
  parameter int COUNT_BITS    = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_enable,
  input  logic [pgcm_pkg::INDEX_W-1:0]      cfg_index,
  input  logic [pgcm_pkg::COLOR_W-1:0]      cfg_data,
  pgcm_count_if.sink                        pixel_in,
  pgcm_color_if.source                      color_out
);

  localparam int QUOT_BITS = FRACTION_BITS + pgcm_pkg::SEG_W;
  localparam int NUM_CELLS = QUOT_BITS;
  localparam int LIMIT_W   = (COUNT_BITS < pgcm_pkg::LIMIT_CFG_W) ?
                             COUNT_BITS : pgcm_pkg::LIMIT_CFG_W;

  logic [COUNT_BITS-1:0] limit;
  pgcm_pkg::palette_t    palette;

  logic                  link_valid [NUM_CELLS+1];
  logic                  link_ready [NUM_CELLS+1];
  logic                  link_sat   [NUM_CELLS+1];
  logic [COUNT_BITS-1:0] link_rem   [NUM_CELLS+1];
  logic [QUOT_BITS-1:0]  link_quot  [NUM_CELLS+1];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      limit   <= COUNT_BITS'(pgcm_pkg::LIMIT_RESET);
      palette <= pgcm_pkg::PALETTE_RESET;
    end else if (cfg_write_enable) begin
      if (cfg_index == pgcm_pkg::REG_LIMIT) begin
        limit <= COUNT_BITS'(cfg_data[LIMIT_W-1:0]);
      end else if (cfg_index inside {[pgcm_pkg::REG_PAL0:pgcm_pkg::REG_PAL4]}) begin
        palette[pgcm_pkg::ENTRY_W'(cfg_index - pgcm_pkg::REG_PAL0)] <= cfg_data;
      end
    end
  end

  // head of the chain: the count itself is the first remainder
  assign link_valid[0]  = pixel_in.valid;
  assign pixel_in.ready = link_ready[0];
  assign link_sat[0]    = (pixel_in.iteration_count >= limit);
  assign link_rem[0]    = pixel_in.iteration_count;
  assign link_quot[0]   = '0;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    pgcm_div_cell #(
      .COUNT_BITS (COUNT_BITS),
      .QUOT_BITS  (QUOT_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .limit     (limit),
      .in_valid  (link_valid[i]),
      .in_ready  (link_ready[i]),
      .in_sat    (link_sat[i]),
      .in_rem    (link_rem[i]),
      .in_quot   (link_quot[i]),
      .out_valid (link_valid[i+1]),
      .out_ready (link_ready[i+1]),
      .out_sat   (link_sat[i+1]),
      .out_rem   (link_rem[i+1]),
      .out_quot  (link_quot[i+1])
    );
  end

  pgcm_blend #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_blend (
    .clk       (clk),
    .rst       (rst),
    .palette   (palette),
    .in_valid  (link_valid[NUM_CELLS]),
    .in_ready  (link_ready[NUM_CELLS]),
    .in_sat    (link_sat[NUM_CELLS]),
    .in_quot   (link_quot[NUM_CELLS]),
    .out_valid (color_out.valid),
    .out_ready (color_out.ready),
    .out_red   (color_out.red),
    .out_green (color_out.green),
    .out_blue  (color_out.blue)
  );

endmodule

FILE: verif/palette_gradient_color_map_checker.sv
// checker: mirrors the register writes, predicts each pixel color and compares color_out
`timescale 1ns / 100ps

module palette_gradient_color_map_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_enable,
  input  logic [pgcm_pkg::INDEX_W-1:0] cfg_index,
  input  logic [pgcm_pkg::COLOR_W-1:0] cfg_data,
  pgcm_count_if                        pixel_in,
  pgcm_color_if                        color_out,
  output int unsigned                  mismatch_count,
  output int unsigned                  colors_pending
);

  localparam int FRAC_BITS   = 16;
  localparam int LAST_ENTRY  = pgcm_pkg::PALETTE_SIZE - 1;
  localparam int MAX_REPORTS = 10;
  localparam int FIFO_DEPTH  = 64;
  localparam int PTR_W       = 6;

  typedef struct packed {
    logic [pgcm_pkg::CHAN_W-1:0] red;
    logic [pgcm_pkg::CHAN_W-1:0] green;
    logic [pgcm_pkg::CHAN_W-1:0] blue;
  } rgb_t;

  logic [pgcm_pkg::LIMIT_CFG_W-1:0] gradient_limit;
  pgcm_pkg::palette_t               palette;
  rgb_t                             expected_colors [FIFO_DEPTH];
  logic [PTR_W-1:0]                 wr_ptr;
  logic [PTR_W-1:0]                 rd_ptr;

  function automatic logic [pgcm_pkg::CHAN_W-1:0] blend_channel(
    input logic [pgcm_pkg::CHAN_W-1:0] lo,
    input logic [pgcm_pkg::CHAN_W-1:0] hi,
    input logic [63:0]                 weight);
    logic [63:0] one;
    logic [63:0] acc;
    one = 64'd1 << FRAC_BITS;
    acc = lo * (one - weight) + hi * weight;
    return acc[FRAC_BITS +: pgcm_pkg::CHAN_W];
  endfunction

  function automatic rgb_t predict_color(input logic [15:0] count);
    logic [63:0] position;
    logic [63:0] weight;
    int          seg;
    rgb_t        lo;
    rgb_t        hi;
    rgb_t        mixed;
    // also covers a limit of zero: every count is at or above it
    if (count >= gradient_limit) return rgb_t'(palette[LAST_ENTRY]);
    // 4 * count / limit with FRAC_BITS fraction bits
    position = ({48'd0, count} << (FRAC_BITS + 2)) / {48'd0, gradient_limit};
    seg = int'(position >> FRAC_BITS);
    if (seg > pgcm_pkg::PALETTE_SIZE - 2) seg = pgcm_pkg::PALETTE_SIZE - 2;
    weight = position & ((64'd1 << FRAC_BITS) - 1);
    lo = rgb_t'(palette[seg]);
    hi = rgb_t'(palette[seg + 1]);
    mixed.red   = blend_channel(lo.red, hi.red, weight);
    mixed.green = blend_channel(lo.green, hi.green, weight);
    mixed.blue  = blend_channel(lo.blue, hi.blue, weight);
    return mixed;
  endfunction

  always @(posedge clk) begin
    rgb_t want;
    rgb_t got;
    if (rst) begin
      gradient_limit = pgcm_pkg::LIMIT_RESET;
      palette = pgcm_pkg::PALETTE_RESET;
      wr_ptr = '0;
      rd_ptr = '0;
      mismatch_count = 0;
      colors_pending = 0;
    end else begin
      if (cfg_write_enable) begin
        case (cfg_index)
          pgcm_pkg::REG_LIMIT: gradient_limit = cfg_data[pgcm_pkg::LIMIT_CFG_W-1:0];
          pgcm_pkg::REG_PAL0, pgcm_pkg::REG_PAL1, pgcm_pkg::REG_PAL2,
          pgcm_pkg::REG_PAL3, pgcm_pkg::REG_PAL4:
            palette[cfg_index - pgcm_pkg::REG_PAL0] = cfg_data;
          default: ;
        endcase
      end
      if (pixel_in.valid && pixel_in.ready) begin
        if (colors_pending == FIFO_DEPTH) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: more counts in flight than the checker can hold", $realtime);
        end else begin
          expected_colors[wr_ptr] = predict_color(pixel_in.iteration_count);
          wr_ptr = wr_ptr + 1'b1;
          colors_pending++;
        end
      end
      if (color_out.valid && color_out.ready) begin
        got = '{color_out.red, color_out.green, color_out.blue};
        if (colors_pending == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: color r=%02h g=%02h b=%02h with no count waiting",
                     $realtime, got.red, got.green, got.blue);
        end else begin
          want = expected_colors[rd_ptr];
          rd_ptr = rd_ptr + 1'b1;
          colors_pending--;
          if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display({"%0t: color mismatch: expected r=%02h g=%02h b=%02h,",
                        " got r=%02h g=%02h b=%02h"},
                       $realtime, want.red, want.green, want.blue,
                       got.red, got.green, got.blue);
          end
        end
      end
    end
  end

endmodule

FILE: verif/palette_gradient_color_map_top_tb.sv
// testbench top: clock, reset, register phases, count stimulus, color_out backpressure, verdict
`timescale 1ns / 100ps

module palette_gradient_color_map_top_tb;

  localparam int COUNT_BITS    = 16;
  localparam int FRACTION_BITS = 16;
  localparam int LATENCY       = FRACTION_BITS + 3;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int STALL_CYCLES  = 160;
  localparam int PRESSURE_ITEMS = 80;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 96;

  // indexes with no register behind them
  localparam logic [pgcm_pkg::INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [pgcm_pkg::INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                             clk;
  logic                             rst;
  logic                             cfg_write_enable;
  logic [pgcm_pkg::INDEX_W-1:0]     cfg_index;
  logic [pgcm_pkg::COLOR_W-1:0]     cfg_data;
  int unsigned                      mismatch_count;
  int unsigned                      colors_pending;
  logic                             stall_req;
  bit                               gaps_on;
  int                               burst_left;
  logic [pgcm_pkg::LIMIT_CFG_W-1:0] phase_limit;

  pgcm_count_if #(.COUNT_BITS(COUNT_BITS)) pixel_in ();
  pgcm_color_if color_out ();

  palette_gradient_color_map_top #(
    .COUNT_BITS   (COUNT_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_enable(cfg_write_enable),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .pixel_in        (pixel_in),
    .color_out       (color_out)
  );

  palette_gradient_color_map_checker color_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_enable(cfg_write_enable),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .pixel_in        (pixel_in),
    .color_out       (color_out),
    .mismatch_count  (mismatch_count),
    .colors_pending  (colors_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("** palette_gradient_color_map_top: FAILED **");
    $finish;
  end

  // receiver: always-ready, coin-flip, sparse and mostly-ready stretches, plus one long hold-off
  initial begin
    int mode;
    int span;
    bit stall_served;
    color_out.ready = 1'b0;
    stall_served = 1'b0;
    wait (rst === 1'b0);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 120);
      repeat (span) begin
        @(posedge clk);
        if (stall_req && !stall_served) begin
          stall_served = 1'b1;
          color_out.ready <= 1'b0;
          repeat (STALL_CYCLES) @(posedge clk);
        end
        case (mode)
          0:       color_out.ready <= 1'b1;
          1:       color_out.ready <= 1'($urandom_range(0, 1));
          2:       color_out.ready <= ($urandom_range(0, 3) == 0);
          default: color_out.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // one transaction on pixel_in, with a random gap whenever a burst runs out
  task automatic push_count(input logic [COUNT_BITS-1:0] count);
    if (gaps_on && burst_left == 0) begin
      pixel_in.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
    end
    pixel_in.valid <= 1'b1;
    pixel_in.iteration_count <= count;
    do @(posedge clk); while (!pixel_in.ready);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic drain();
    pixel_in.valid <= 1'b0;
    @(negedge clk);
    while (colors_pending != 0) @(negedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pgcm_pkg::INDEX_W-1:0] idx,
                           input logic [pgcm_pkg::COLOR_W-1:0] value);
    cfg_write_enable <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [pgcm_pkg::LIMIT_CFG_W-1:0] limit,
                               input pgcm_pkg::palette_t entries,
                               input bit with_spares);
    // junk above the limit field must be dropped
    write_reg(pgcm_pkg::REG_LIMIT, {8'($urandom_range(0, 255)), limit});
    for (int i = 0; i < pgcm_pkg::PALETTE_SIZE; i++)
      write_reg(pgcm_pkg::INDEX_W'(pgcm_pkg::REG_PAL0 + i), entries[i]);
    if (with_spares) begin
      write_reg(REG_SPARE_LO, 24'($urandom));
      write_reg(REG_SPARE_HI, 24'($urandom));
    end
    cfg_write_enable <= 1'b0;
    phase_limit = limit;
  endtask

  function automatic logic [pgcm_pkg::COLOR_W-1:0] pick_color();
    case ($urandom_range(0, 5))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic pgcm_pkg::palette_t pick_palette();
    pgcm_pkg::palette_t entries;
    for (int i = 0; i < pgcm_pkg::PALETTE_SIZE; i++) entries[i] = pick_color();
    return entries;
  endfunction

  function automatic logic [pgcm_pkg::LIMIT_CFG_W-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(11, 64));
      1:       return 16'($urandom_range(65, 2000));
      2:       return 16'($urandom_range(11, 65535));
      3:       return 16'hFFFF;
      4:       return 16'd11;
      default: return 16'($urandom_range(1, 10));
    endcase
  endfunction

  function automatic logic [COUNT_BITS-1:0] pick_count();
    int unsigned r;
    int          above;
    r = $urandom_range(0, 9);
    if (phase_limit != 0 && r < 6) return COUNT_BITS'($urandom_range(0, phase_limit - 1));
    if (r == 6) begin
      above = phase_limit + $urandom_range(0, 8);
      return (above > 65535) ? 16'hFFFF : COUNT_BITS'(above);
    end
    if (r == 7 && phase_limit != 0) return phase_limit - 1'b1;
    return COUNT_BITS'($urandom);
  endfunction

  initial begin
    rst = 1'b1;
    cfg_write_enable = 1'b0;
    cfg_index = pgcm_pkg::REG_LIMIT;
    cfg_data = '0;
    pixel_in.valid = 1'b0;
    pixel_in.iteration_count = '0;
    stall_req = 1'b0;
    gaps_on = 1'b1;
    burst_left = 0;
    phase_limit = 16'd100;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default palette: segment edges and the limit itself
    push_count(16'd0);
    push_count(16'd1);
    push_count(16'd25);
    push_count(16'd50);
    push_count(16'd75);
    push_count(16'd99);
    push_count(16'd100);
    push_count(16'hFFFF);
    drain();

    // widest limit, palette swinging between black and white
    load_settings(16'hFFFF, {24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF}, 1'b0);
    push_count(16'd16383);
    push_count(16'd16384);
    push_count(16'd32768);
    push_count(16'd49151);
    push_count(16'hFFFE);
    push_count(16'hFFFF);
    drain();

    // zero limit: always the last entry, no division
    load_settings(16'd0, pick_palette(), 1'b0);
    push_count(16'd0);
    push_count(16'h3039);
    drain();

    load_settings(16'd11, pick_palette(), 1'b0);
    push_count(16'd0);
    push_count(16'd3);
    push_count(16'd5);
    push_count(16'd8);
    push_count(16'd10);
    push_count(16'd11);
    drain();

    // limit below eleven, then writes to unused indexes that must change nothing
    load_settings(16'd1, pick_palette(), 1'b1);
    push_count(16'd0);
    push_count(16'd1);
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      load_settings(pick_limit(), pick_palette(), $urandom_range(0, 3) == 0);
      if (phase == 0) begin
        // back-to-back counts against a long receiver hold-off
        gaps_on = 1'b0;
        stall_req <= 1'b1;
        repeat (PRESSURE_ITEMS) push_count(pick_count());
        gaps_on = 1'b1;
      end
      repeat (PHASE_ITEMS) push_count(pick_count());
      drain();
    end

    repeat (LATENCY) @(posedge clk);
    if (mismatch_count == 0 && colors_pending == 0)
      $display("** palette_gradient_color_map_top: PASSED **");
    else
      $display("** palette_gradient_color_map_top: FAILED **");
    $finish;
  end

endmodule

FILE: filelist.f
sv/pgcm_pkg.sv
sv/pgcm_if.sv
sv/pgcm_div_cell.sv
sv/pgcm_blend.sv
sv/palette_gradient_color_map_top.sv
verif/palette_gradient_color_map_checker.sv
verif/palette_gradient_color_map_top_tb.sv
